// ===== rtl/core/renc_pkg.sv =====
// ----------------------------------------------------------------------------
// Rotary encoder front end package
// Shared widths, register indexes, action codes, handshake struct and the
// quadrature step table.
// ----------------------------------------------------------------------------
package renc_pkg;

    localparam int STEP_COUNT_WIDTH = 16;
    localparam int TIMER_W          = 20;
    localparam int AGREE_W          = 16;
    localparam int PENDING_W        = 16;
    localparam int APB_ADDR_W       = 4;
    localparam int APB_DATA_W       = 32;

    localparam logic [TIMER_W-1:0]          TIMER_MAX = {TIMER_W{1'b1}};
    localparam logic [AGREE_W-1:0]          AGREE_MAX = {AGREE_W{1'b1}};
    localparam logic [STEP_COUNT_WIDTH-1:0] STEP_ONE  = STEP_COUNT_WIDTH'(1);

    // Register reset values.
    localparam logic [TIMER_W-1:0] BOOT_GUARD_RST   = TIMER_W'(4688);
    localparam logic [AGREE_W-1:0] BUTTON_STABLE_RST = AGREE_W'(313);
    localparam logic [TIMER_W-1:0] LONG_PRESS_RST   = TIMER_W'(31250);

    // Register indexes (word address bits).
    localparam logic [1:0] REG_BOOT_GUARD    = 2'd0;
    localparam logic [1:0] REG_BUTTON_STABLE = 2'd1;
    localparam logic [1:0] REG_LONG_PRESS    = 2'd2;

    // Action codes.
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_TAKE  = 2'd1;
    localparam logic [1:0] ACT_FLUSH = 2'd2;

    localparam logic [1:0] CODE_REST = 2'b11;

    typedef struct packed {
        logic advance;
        logic tick;
        logic take;
        logic flush;
    } ctrl_t;

    // Quarter step for {previous code, new code}.
    function automatic logic signed [1:0] gray_step(input logic [3:0] idx);
        logic signed [1:0] s;
        case (idx)
            4'd1, 4'd7, 4'd8, 4'd14:  s = 2'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: s = -2'sd1;
            default:                  s = 2'sd0;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/core/renc_rot.sv =====
// ----------------------------------------------------------------------------
// Rotation decoder
// Tracks the phase code history, accumulates quarter steps and commits
// whole clicks to the step total once the boot guard has opened.
// ----------------------------------------------------------------------------
module renc_rot (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  renc_pkg::ctrl_t                       ctrl,
    input  logic [1:0]                            code,
    input  logic [renc_pkg::TIMER_W-1:0]          boot_guard_ticks,
    output logic [renc_pkg::STEP_COUNT_WIDTH-1:0] step_view
);

    logic [7:0]                            hist_reg, hist_next;
    logic signed [3:0]                     partial_reg, partial_next;
    logic [renc_pkg::STEP_COUNT_WIDTH-1:0] step_reg, step_next;
    logic [renc_pkg::TIMER_W-1:0]          guard_timer_reg, guard_timer_next;
    logic                                  guard_reg, guard_next;

    logic [7:0]                            hist_tick;
    logic signed [3:0]                     sum;
    logic signed [3:0]                     pc;
    logic [renc_pkg::STEP_COUNT_WIDTH-1:0] step_tick;

    always_comb
    begin
        guard_next = guard_reg | (guard_timer_reg >= boot_guard_ticks);
        hist_tick  = {hist_reg[5:0], code};
        sum        = partial_reg + 4'(renc_pkg::gray_step(hist_tick[3:0]));
        pc         = (hist_tick == 8'hFF) ? 4'sd0 : sum;
        step_tick  = step_reg;
        if (pc > 4'sd3)
        begin
            if (guard_next)
                step_tick = step_reg + renc_pkg::STEP_ONE;
            pc = 4'sd0;
        end
        else if (pc < -4'sd3)
        begin
            if (guard_next)
                step_tick = step_reg - renc_pkg::STEP_ONE;
            pc = 4'sd0;
        end
        if (hist_tick[1:0] == renc_pkg::CODE_REST)
            pc = 4'sd0;
    end

    always_comb
    begin
        hist_next        = hist_reg;
        partial_next     = partial_reg;
        step_next        = step_reg;
        guard_timer_next = guard_timer_reg;
        step_view        = step_reg;
        if (ctrl.tick)
        begin
            hist_next    = hist_tick;
            partial_next = pc;
            step_next    = step_tick;
            step_view    = step_tick;
            if (guard_timer_reg != renc_pkg::TIMER_MAX)
                guard_timer_next = guard_timer_reg + renc_pkg::TIMER_W'(1);
        end
        else if (ctrl.flush)
        begin
            hist_next    = {6'd0, hist_reg[1:0]};
            partial_next = 4'sd0;
            step_next    = '0;
            step_view    = '0;
        end
        else if (ctrl.take)
        begin
            step_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg        <= 8'd3;
            partial_reg     <= 4'sd0;
            step_reg        <= '0;
            guard_timer_reg <= '0;
            guard_reg       <= 1'b0;
        end
        else if (ctrl.advance)
        begin
            hist_reg        <= hist_next;
            partial_reg     <= partial_next;
            step_reg        <= step_next;
            guard_timer_reg <= guard_timer_next;
            if (ctrl.tick)
                guard_reg <= guard_next;
        end
    end

    // The partial count is cleared as soon as it reaches a full click.
    a_partial_range : assert property (@(posedge clk) disable iff (!rst_n)
        (partial_reg <= 4'sd3) && (partial_reg >= -4'sd3))
        else $error("partial count out of range");

    // Once open, the boot guard never closes.
    a_guard_latch : assert property (@(posedge clk) disable iff (!rst_n)
        guard_reg |=> guard_reg)
        else $error("boot guard closed again");

endmodule

// ===== rtl/core/renc_btn.sv =====
// ----------------------------------------------------------------------------
// Button debouncer
// Accepts a level change after enough consecutive differing samples and
// raises press, release and long-press flags until they are taken.
// ----------------------------------------------------------------------------
module renc_btn (
    input  logic                          clk,
    input  logic                          rst_n,
    input  renc_pkg::ctrl_t               ctrl,
    input  logic                          level,
    input  logic [renc_pkg::AGREE_W-1:0]  button_stable_ticks,
    input  logic [renc_pkg::TIMER_W-1:0]  long_press_ticks,
    output logic                          press_view,
    output logic                          release_view,
    output logic                          long_view
);

    logic                         state_reg, state_next;
    logic [renc_pkg::AGREE_W-1:0] agree_reg, agree_next;
    logic [renc_pkg::TIMER_W-1:0] held_reg, held_next;
    logic                         long_fired_reg, long_fired_next;
    logic                         press_reg, press_next;
    logic                         release_reg, release_next;
    logic                         long_reg, long_next;

    logic [renc_pkg::AGREE_W-1:0] agree_inc;
    logic [renc_pkg::TIMER_W-1:0] held_mid;
    logic                         state_upd, fired_upd, press_upd, release_upd, long_upd;
    logic [renc_pkg::AGREE_W-1:0] agree_upd;

    always_comb
    begin
        state_upd   = state_reg;
        fired_upd   = long_fired_reg;
        press_upd   = press_reg;
        release_upd = release_reg;
        long_upd    = long_reg;
        held_mid    = held_reg;
        agree_inc   = (agree_reg != renc_pkg::AGREE_MAX) ?
                      agree_reg + renc_pkg::AGREE_W'(1) : agree_reg;
        agree_upd   = '0;
        if (level != state_reg)
        begin
            agree_upd = agree_inc;
            if (agree_inc >= button_stable_ticks)
            begin
                agree_upd = '0;
                state_upd = level;
                if (!level)
                begin
                    press_upd = 1'b1;
                    held_mid  = '0;
                    fired_upd = 1'b0;
                end
                else
                begin
                    release_upd = 1'b1;
                end
            end
        end
        if (!state_upd && !fired_upd && (held_mid >= long_press_ticks))
        begin
            fired_upd = 1'b1;
            long_upd  = 1'b1;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        agree_next      = agree_reg;
        held_next       = held_reg;
        long_fired_next = long_fired_reg;
        press_next      = press_reg;
        release_next    = release_reg;
        long_next       = long_reg;
        press_view      = press_reg;
        release_view    = release_reg;
        long_view       = long_reg;
        if (ctrl.tick)
        begin
            state_next      = state_upd;
            agree_next      = agree_upd;
            long_fired_next = fired_upd;
            press_next      = press_upd;
            release_next    = release_upd;
            long_next       = long_upd;
            press_view      = press_upd;
            release_view    = release_upd;
            long_view       = long_upd;
            held_next       = (held_mid != renc_pkg::TIMER_MAX) ?
                              held_mid + renc_pkg::TIMER_W'(1) : held_mid;
        end
        else if (ctrl.take)
        begin
            press_next   = 1'b0;
            release_next = 1'b0;
            long_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= 1'b1;
            agree_reg      <= '0;
            held_reg       <= '0;
            long_fired_reg <= 1'b0;
            press_reg      <= 1'b0;
            release_reg    <= 1'b0;
            long_reg       <= 1'b0;
        end
        else if (ctrl.advance)
        begin
            state_reg      <= state_next;
            agree_reg      <= agree_next;
            held_reg       <= held_next;
            long_fired_reg <= long_fired_next;
            press_reg      <= press_next;
            release_reg    <= release_next;
            long_reg       <= long_next;
        end
    end

    // A long press can only fire while the debounced button is pressed.
    a_long_while_pressed : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(long_fired_reg) |-> !state_reg)
        else $error("long press fired while released");

endmodule

// ===== rtl/core/rotary_encoder_front_end_top.sv =====
// ----------------------------------------------------------------------------
// Rotary encoder front end
// Quadrature decoder with boot guard and push-button debounce, behind a
// request register, a result register and an APB-style register port.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Payload
//  request   in         req_valid/req_stall   action, phase_a, phase_b,
//                                             button_level
//  result    out        rsp_valid/rsp_stall   pending_steps, press_event,
//                                             release_event, long_press_event
//  config    in         psel/penable/pready   paddr, pwdata, prdata
//
// One request per cycle is sustained while the result is not stalled. An
// accepted request is held in the request register and then processed into
// the result register, from which its result is taken.
// A stalled result holds the result register; the request register keeps
// taking a request until it too is full, then req_stall rises.
// Reset is asynchronous and active low for control and config state only.
// ----------------------------------------------------------------------------
module rotary_encoder_front_end_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic [1:0]                          action,
    input  logic                                phase_a,
    input  logic                                phase_b,
    input  logic                                button_level,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic signed [renc_pkg::PENDING_W-1:0] pending_steps,
    output logic                                press_event,
    output logic                                release_event,
    output logic                                long_press_event,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [renc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [renc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [renc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    logic [renc_pkg::TIMER_W-1:0] boot_guard_reg;
    logic [renc_pkg::AGREE_W-1:0] button_stable_reg;
    logic [renc_pkg::TIMER_W-1:0] long_press_reg;

    logic       in_v_reg, in_v_next;
    logic [1:0] action_reg;
    logic [1:0] code_reg;
    logic       level_reg;
    logic       out_v_reg, out_v_next;

    logic            accept;
    logic            advance;
    logic            cfg_write;
    renc_pkg::ctrl_t ctrl;

    logic [renc_pkg::STEP_COUNT_WIDTH-1:0] step_view;
    logic                                  press_view, release_view, long_view;
    logic signed [31:0]                    step_ext;

    // ---------------- register port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boot_guard_reg    <= renc_pkg::BOOT_GUARD_RST;
            button_stable_reg <= renc_pkg::BUTTON_STABLE_RST;
            long_press_reg    <= renc_pkg::LONG_PRESS_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                renc_pkg::REG_BOOT_GUARD:
                    boot_guard_reg <= pwdata[renc_pkg::TIMER_W-1:0];
                renc_pkg::REG_BUTTON_STABLE:
                    button_stable_reg <= pwdata[renc_pkg::AGREE_W-1:0];
                renc_pkg::REG_LONG_PRESS:
                    long_press_reg <= pwdata[renc_pkg::TIMER_W-1:0];
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            renc_pkg::REG_BOOT_GUARD:
                prdata = renc_pkg::APB_DATA_W'(boot_guard_reg);
            renc_pkg::REG_BUTTON_STABLE:
                prdata = renc_pkg::APB_DATA_W'(button_stable_reg);
            renc_pkg::REG_LONG_PRESS:
                prdata = renc_pkg::APB_DATA_W'(long_press_reg);
            default:
                prdata = '0;
        endcase
    end

    // ---------------- request and result registers ----------------
    assign advance   = in_v_reg && (!out_v_reg || !rsp_stall);
    assign req_stall = in_v_reg && !advance;
    assign accept    = req_valid && !req_stall;

    assign ctrl.advance = advance;
    assign ctrl.tick    = (action_reg == renc_pkg::ACT_TICK);
    assign ctrl.take    = (action_reg == renc_pkg::ACT_TAKE);
    assign ctrl.flush   = (action_reg == renc_pkg::ACT_FLUSH);

    always_comb
    begin
        in_v_next = in_v_reg;
        if (accept)
            in_v_next = 1'b1;
        else if (advance)
            in_v_next = 1'b0;

        out_v_next = out_v_reg;
        if (advance)
            out_v_next = 1'b1;
        else if (out_v_reg && !rsp_stall)
            out_v_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            in_v_reg  <= in_v_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action;
            code_reg   <= {phase_a, phase_b};
            level_reg  <= button_level;
        end
    end

    renc_rot u_rot (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctrl             (ctrl),
        .code             (code_reg),
        .boot_guard_ticks (boot_guard_reg),
        .step_view        (step_view)
    );

    renc_btn u_btn (
        .clk                 (clk),
        .rst_n               (rst_n),
        .ctrl                (ctrl),
        .level               (level_reg),
        .button_stable_ticks (button_stable_reg),
        .long_press_ticks    (long_press_reg),
        .press_view          (press_view),
        .release_view        (release_view),
        .long_view           (long_view)
    );

    // The step total is sign-extended to 32 bits, then cut to the port width.
    assign step_ext = 32'(signed'(step_view));

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pending_steps    <= step_ext[renc_pkg::PENDING_W-1:0];
            press_event      <= press_view;
            release_event    <= release_view;
            long_press_event <= long_view;
        end
    end

    assign rsp_valid = out_v_reg;

    // A held request must move on whenever the result register is free.
    a_advance_free : assert property (@(posedge clk) disable iff (!rst_n)
        (in_v_reg && !out_v_reg) |-> advance)
        else $error("request held with free result register");

    // Every request that moves on produces a result in the next cycle.
    a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_v_reg)
        else $error("advanced request left no result");

endmodule
